// ----- rtl/core/ils_pkg.sv -----
package ils_pkg;

	localparam int unsigned OpW    = 3;
	localparam int unsigned PosW   = 8;
	localparam int unsigned DataW  = 32;
	localparam int unsigned StW    = 2;
	localparam int unsigned CountW = 9;

	typedef enum logic [OpW-1:0] {
		OP_READ      = 3'd0,
		OP_INS_FRONT = 3'd1,
		OP_APPEND    = 3'd2,
		OP_INS_AT    = 3'd3,
		OP_DELETE    = 3'd4
	} op_t;

	typedef enum logic [StW-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef logic signed [DataW-1:0] data_t;

	typedef struct packed {
		logic            ins;
		logic            del;
		logic            rd;
		logic [PosW-1:0] pos;
	} cell_ctrl_t;

endpackage

// ----- rtl/core/ils_req_if.sv -----
interface ils_req_if;
	import ils_pkg::*;

	logic              valid;
	logic              ready;
	logic [OpW-1:0]    op;
	logic [PosW-1:0]   position;
	data_t             value;

	modport source (output valid, output op, output position, output value, input ready);
	modport sink (input valid, input op, input position, input value, output ready);

endinterface

// ----- rtl/core/ils_rsp_if.sv -----
interface ils_rsp_if;
	import ils_pkg::*;

	logic              valid;
	logic              ready;
	data_t             read_value;
	logic [StW-1:0]    status;
	logic [CountW-1:0] count;

	modport source (output valid, output read_value, output status, output count, input ready);
	modport sink (input valid, input read_value, input status, input count, output ready);

endinterface

// ----- rtl/core/ils_cell.sv -----
module ils_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic               clk,
	input  ils_pkg::cell_ctrl_t ctrl,
	input  ils_pkg::data_t     ins_value,
	input  ils_pkg::data_t     prev_data,
	input  ils_pkg::data_t     next_data,
	output ils_pkg::data_t     data,
	output ils_pkg::data_t     rd_data
);
	import ils_pkg::*;

	localparam logic [PosW-1:0] MyIdx = PosW'(IDX);

	data_t data_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (MyIdx == ctrl.pos) begin
				data_q <= ins_value;
			end else if (MyIdx > ctrl.pos) begin
				data_q <= prev_data;
			end
		end else if (ctrl.del) begin
			if (MyIdx >= ctrl.pos) begin
				data_q <= next_data;
			end
		end
	end

	assign data    = data_q;
	assign rd_data = (ctrl.rd && (MyIdx == ctrl.pos)) ? data_q : '0;

endmodule

// ----- rtl/core/indexed_list_store.sv -----
// Ordered store of up to CAPACITY signed 32-bit values in a row of cells, one
// value per cell. Insert and delete move every later cell by one place in the
// same cycle; one request is taken per cycle while rsp.ready holds, and its
// response appears in the output register on the next cycle; a new request is
// taken while that response is being taken. Reads and deletes at or past the
// count, inserts past it and unknown ops report out of range; inserts into a
// full store report full. Every response carries the count after the request.
module indexed_list_store #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic clk,
	input  logic arst_n,
	ils_req_if.sink   req,
	ils_rsp_if.source rsp
);
	import ils_pkg::*;

	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     count_d;
	logic              rsp_valid_q;
	data_t             read_value_q;
	logic [StW-1:0]    status_q;
	logic [CountW-1:0] count_out_q;

	logic              xfer;
	logic              full;
	logic [CountW-1:0] pos9;
	logic [CountW-1:0] cnt9;
	cell_ctrl_t        dec;
	cell_ctrl_t        ctrl;
	status_t           st_d;
	data_t             rd_or;
	data_t             rd_d;

	data_t cell_data [CAPACITY];
	data_t cell_rd   [CAPACITY];

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign xfer      = req.valid && req.ready;
	assign full      = (count_q == CW'(CAPACITY));
	assign pos9      = CountW'(req.position);
	assign cnt9      = CountW'(count_q);

	always_comb begin
		dec     = '0;
		dec.pos = req.position;
		st_d    = ST_DONE;
		count_d = count_q;
		case (req.op)
			OP_READ: begin
				if (pos9 < cnt9) begin
					dec.rd = 1'b1;
				end else begin
					st_d = ST_RANGE;
				end
			end
			OP_INS_FRONT: begin
				dec.pos = '0;
				if (full) begin
					st_d = ST_FULL;
				end else begin
					dec.ins = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			OP_APPEND: begin
				dec.pos = PosW'(count_q);
				if (full) begin
					st_d = ST_FULL;
				end else begin
					dec.ins = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			OP_INS_AT: begin
				if (pos9 > cnt9) begin
					st_d = ST_RANGE;
				end else if (full) begin
					st_d = ST_FULL;
				end else begin
					dec.ins = 1'b1;
					count_d = count_q + 1'b1;
				end
			end
			OP_DELETE: begin
				if (pos9 < cnt9) begin
					dec.del = 1'b1;
					count_d = count_q - 1'b1;
				end else begin
					st_d = ST_RANGE;
				end
			end
			default: begin
				st_d = ST_RANGE;
			end
		endcase
	end

	always_comb begin
		ctrl     = dec;
		ctrl.ins = dec.ins && xfer;
		ctrl.del = dec.del && xfer;
	end

	// row of cells, each shifting toward its neighbor on insert or delete
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		data_t prev_d;
		data_t next_d;
		if (i == 0) begin : g_first
			assign prev_d = req.value;
		end else begin : g_mid
			assign prev_d = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign next_d = cell_data[i];
		end else begin : g_inner
			assign next_d = cell_data[i+1];
		end
		ils_cell #(
			.IDX(i)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.ins_value(req.value),
			.prev_data(prev_d),
			.next_data(next_d),
			.data     (cell_data[i]),
			.rd_data  (cell_rd[i])
		);
	end

	always_comb begin
		rd_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_or = rd_or | cell_rd[i];
		end
		rd_d = dec.rd ? rd_or : '1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (xfer) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			read_value_q <= rd_d;
			status_q     <= st_d;
			count_out_q  <= CountW'(count_d);
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_value = read_value_q;
	assign rsp.status     = status_q;
	assign rsp.count      = count_out_q;

endmodule

// ----- test/tb_indexed_list_store.sv -----
`timescale 1ns / 1ps

module tb_indexed_list_store;
	import ils_pkg::*;

	localparam int Cap        = 16;
	localparam int DirN       = 28;
	localparam int RandN      = 522;
	localparam int QuietN     = 60;
	localparam int HoldCycles = 80;
	localparam int HoldAt     = 150;
	localparam int DrainAt    = 300;
	localparam int CycleLimit = 200000;

	localparam logic [OpW-1:0] OP_UNKNOWN_LO = 3'd5;
	localparam logic [OpW-1:0] OP_UNKNOWN    = 3'd7;

	typedef struct packed {
		data_t             rd;
		status_t           st;
		logic [CountW-1:0] cnt;
	} list_rsp_t;

	typedef struct packed {
		logic [OpW-1:0]  op;
		logic [PosW-1:0] pos;
		data_t           val;
		logic            typed;
		list_rsp_t       want;
	} list_row_t;

	localparam list_rsp_t NoWant = '{-1, ST_DONE, 9'd0};

	logic clk;
	logic arst_n;

	ils_req_if req_if();
	ils_rsp_if rsp_if();

	indexed_list_store #(.CAPACITY(Cap)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	data_t     list_q[$];
	list_rsp_t rsp_want_q[$];
	logic      row_typed;
	list_rsp_t row_want;
	bit        quiet;
	bit        hold_rsp;
	int        err_cnt;
	int        cycle_cnt;

	list_row_t dir_rows [DirN] = '{
		'{OP_READ,      8'd0,   32'h0000_0000, 1'b1, '{-1, ST_RANGE, 9'd0}},
		'{OP_DELETE,    8'd0,   32'h0000_0000, 1'b1, '{-1, ST_RANGE, 9'd0}},
		'{OP_UNKNOWN,   8'd0,   32'h0000_0000, 1'b1, '{-1, ST_RANGE, 9'd0}},
		'{OP_INS_AT,    8'd1,   32'h0000_0005, 1'b1, '{-1, ST_RANGE, 9'd0}},
		'{OP_INS_AT,    8'd0,   32'h7FFF_FFFF, 1'b1, '{-1, ST_DONE, 9'd1}},
		'{OP_INS_FRONT, 8'd0,   32'h8000_0000, 1'b1, '{-1, ST_DONE, 9'd2}},
		'{OP_APPEND,    8'd0,   32'hFFFF_FFFF, 1'b1, '{-1, ST_DONE, 9'd3}},
		'{OP_INS_AT,    8'd3,   32'h0000_0000, 1'b1, '{-1, ST_DONE, 9'd4}},
		'{OP_INS_AT,    8'd1,   32'h0000_0001, 1'b0, NoWant},
		'{OP_APPEND,    8'd0,   32'h5555_5555, 1'b0, NoWant},
		'{OP_APPEND,    8'hFF,  32'hAAAA_AAAA, 1'b0, NoWant},
		'{OP_APPEND,    8'd0,   32'h0000_FFFF, 1'b0, NoWant},
		'{OP_APPEND,    8'd0,   32'hFFFF_0000, 1'b0, NoWant},
		'{OP_APPEND,    8'd0,   32'h1234_5678, 1'b0, NoWant},
		'{OP_APPEND,    8'd0,   32'h8000_0001, 1'b0, NoWant},
		'{OP_APPEND,    8'd0,   32'h7FFF_FFFE, 1'b0, NoWant},
		'{OP_APPEND,    8'd0,   32'h0F0F_0F0F, 1'b0, NoWant},
		'{OP_APPEND,    8'd0,   32'hF0F0_F0F0, 1'b0, NoWant},
		'{OP_APPEND,    8'd0,   32'h0000_0100, 1'b0, NoWant},
		'{OP_APPEND,    8'd0,   32'hDEAD_0000, 1'b0, NoWant},
		'{OP_INS_FRONT, 8'd0,   32'h0000_0009, 1'b1, '{-1, ST_FULL, 9'd16}},
		'{OP_APPEND,    8'd0,   32'h0000_0009, 1'b1, '{-1, ST_FULL, 9'd16}},
		'{OP_INS_AT,    8'd17,  32'h0000_0009, 1'b1, '{-1, ST_RANGE, 9'd16}},
		'{OP_INS_AT,    8'd16,  32'h0000_0009, 1'b1, '{-1, ST_FULL, 9'd16}},
		'{OP_READ,      8'd15,  32'h0000_0000, 1'b0, NoWant},
		'{OP_READ,      8'd16,  32'h0000_0000, 1'b1, '{-1, ST_RANGE, 9'd16}},
		'{OP_DELETE,    8'd15,  32'h0000_0000, 1'b0, NoWant},
		'{OP_DELETE,    8'd255, 32'h0000_0000, 1'b1, '{-1, ST_RANGE, 9'd15}}
	};

	function automatic list_rsp_t apply_list_op(logic [OpW-1:0] op, logic [PosW-1:0] pos,
			data_t val);
		list_rsp_t r;
		r.rd = -1;
		r.st = ST_DONE;
		case (op)
			OP_READ: begin
				if (pos < list_q.size()) r.rd = list_q[pos];
				else r.st = ST_RANGE;
			end
			OP_INS_FRONT: begin
				if (list_q.size() >= Cap) r.st = ST_FULL;
				else list_q.push_front(val);
			end
			OP_APPEND: begin
				if (list_q.size() >= Cap) r.st = ST_FULL;
				else list_q.push_back(val);
			end
			OP_INS_AT: begin
				if (pos > list_q.size()) r.st = ST_RANGE;
				else if (list_q.size() >= Cap) r.st = ST_FULL;
				else list_q.insert(int'(pos), val);
			end
			OP_DELETE: begin
				if (pos < list_q.size()) list_q.delete(int'(pos));
				else r.st = ST_RANGE;
			end
			default: r.st = ST_RANGE;
		endcase
		r.cnt = CountW'(list_q.size());
		return r;
	endfunction

	// alternating stretches that grow and shrink the list, so it runs full and empty
	function automatic list_row_t random_row(int n);
		list_row_t row;
		int r;
		int cnt;
		int p;
		cnt = list_q.size();
		r = $urandom_range(0, 99);
		if ((n / 40) % 2 == 0) begin
			if (r < 20) row.op = OP_READ;
			else if (r < 35) row.op = OP_INS_FRONT;
			else if (r < 50) row.op = OP_APPEND;
			else if (r < 75) row.op = OP_INS_AT;
			else if (r < 95) row.op = OP_DELETE;
			else row.op = OpW'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN));
		end else begin
			if (r < 20) row.op = OP_READ;
			else if (r < 27) row.op = OP_INS_FRONT;
			else if (r < 34) row.op = OP_APPEND;
			else if (r < 45) row.op = OP_INS_AT;
			else if (r < 95) row.op = OP_DELETE;
			else row.op = OpW'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN));
		end
		p = $urandom_range(0, 9);
		if (p <= 6) row.pos = PosW'($urandom_range(0, cnt));
		else if (p == 7) row.pos = PosW'(cnt);
		else if (p == 8) row.pos = PosW'(cnt + 1);
		else row.pos = PosW'($urandom_range(0, 255));
		case ($urandom_range(0, 9))
			0: row.val = 32'h7FFF_FFFF;
			1: row.val = 32'h8000_0000;
			2: row.val = -1;
			3: row.val = '0;
			default: row.val = data_t'($urandom);
		endcase
		row.typed = 1'b0;
		row.want = NoWant;
		return row;
	endfunction

	task automatic send_item(input list_row_t row);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		req_if.op       <= row.op;
		req_if.position <= row.pos;
		req_if.value    <= row.val;
		row_typed       <= row.typed;
		row_want        <= row.want;
		req_if.valid    <= 1'b1;
		do @(posedge clk); while (!req_if.ready);
		@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CycleLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		list_rsp_t pred;
		list_rsp_t want;
		if (arst_n) begin
			if (req_if.valid && req_if.ready) begin
				pred = apply_list_op(req_if.op, req_if.position, req_if.value);
				rsp_want_q.push_back(row_typed ? row_want : pred);
			end
			if (rsp_if.valid && rsp_if.ready) begin
				if (rsp_want_q.size() == 0) begin
					err_cnt++;
					$display("%0t: unexpected transfer, read_value %0d status %0d count %0d",
						$time, rsp_if.read_value, rsp_if.status, rsp_if.count);
				end else begin
					want = rsp_want_q.pop_front();
					if (rsp_if.read_value !== want.rd) begin
						err_cnt++;
						$display("%0t: read_value expected %0d got %0d",
							$time, want.rd, rsp_if.read_value);
					end
					if (rsp_if.status !== want.st) begin
						err_cnt++;
						$display("%0t: status expected %0d got %0d",
							$time, want.st, rsp_if.status);
					end
					if (rsp_if.count !== want.cnt) begin
						err_cnt++;
						$display("%0t: count expected %0d got %0d",
							$time, want.cnt, rsp_if.count);
					end
				end
			end
		end
	end

	initial begin
		int stall_left;
		int run_left;
		int hold_left;
		stall_left = 0;
		run_left = 0;
		hold_left = 0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				hold_rsp = 1'b0;
				hold_left = HoldCycles;
			end
			if (hold_left > 0) begin
				rsp_if.ready <= 1'b0;
				hold_left--;
			end else if (quiet) begin
				rsp_if.ready <= 1'b1;
			end else begin
				if (stall_left == 0 && run_left == 0) begin
					if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 19);
					else run_left = $urandom_range(1, 30);
				end
				if (stall_left > 0) begin
					rsp_if.ready <= 1'b0;
					stall_left--;
				end else begin
					rsp_if.ready <= 1'b1;
					run_left--;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req_if.valid    <= 1'b0;
		req_if.op       <= OP_READ;
		req_if.position <= '0;
		req_if.value    <= '0;
		row_typed       <= 1'b0;
		row_want        <= NoWant;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) send_item(dir_rows[i]);

		for (int n = 0; n < RandN; n++) begin
			if (n == RandN - QuietN) quiet = 1'b1;
			// long receiver hold-off while requests keep being offered
			if (n == HoldAt) hold_rsp = 1'b1;
			if (n == DrainAt) begin
				req_if.valid <= 1'b0;
				do @(negedge clk); while (rsp_want_q.size() != 0);
			end
			send_item(random_row(n));
		end
		req_if.valid <= 1'b0;

		while (rsp_want_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (err_cnt == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
